[rtl/plt_pkg.sv]
`timescale 1ns / 1ps

package plt_pkg;

  // Field widths of the request and response
  localparam int unsigned OP_W    = 2;
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned LAT_W   = 32;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned COUNT_W = 5;

  // Configuration registers
  localparam int unsigned CAP_CFG_W  = 5;
  localparam int unsigned TMO_W      = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 1'b1;

  localparam logic [CAP_CFG_W-1:0] CAP_RESET = 5'd16;
  localparam logic [TMO_W-1:0]     TMO_RESET = 32'd60000;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_SWEEP  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    SCAN_SEARCH,
    SCAN_SHIFT,
    SCAN_SWEEP
  } scan_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SEARCH,
    ST_SHIFT,
    ST_APPEND,
    ST_SWEEP,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [KEY_W-1:0]  peer_key;
    logic [ADDR_W-1:0] peer_address;
    logic [PORT_W-1:0] peer_port;
    logic [LAT_W-1:0]  latency_bits;
    logic [TIME_W-1:0] now_time;
  } req_t;

  typedef struct packed {
    logic               status;
    logic [LAT_W-1:0]   found_latency;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic       load;
    logic       scan_start;
    scan_mode_e scan_mode;
    logic       write_hit;
    logic       append;
    logic       commit;
    logic       result_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            scan_busy;
    logic            hit;
    logic            full;
    logic            out_free;
  } status_t;

endpackage

[rtl/plt_ram.sv]
`timescale 1ns / 1ps

module plt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/plt_ctrl.sv]
`timescale 1ns / 1ps

module plt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  plt_pkg::status_t status_i,
  output plt_pkg::cmd_t    cmd_o
);

  import plt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.scan_mode  = SCAN_SEARCH;
    in_ready_o       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (status_i.op) inside
          OP_INSERT, OP_LOOKUP: begin
            cmd_o.scan_start = 1'b1;
            cmd_o.scan_mode  = SCAN_SEARCH;
            state_d          = ST_SEARCH;
          end
          OP_SWEEP: begin
            cmd_o.scan_start = 1'b1;
            cmd_o.scan_mode  = SCAN_SWEEP;
            state_d          = ST_SWEEP;
          end
          default: begin
            state_d = ST_FINISH;
          end
        endcase
      end
      ST_SEARCH: begin
        if (!status_i.scan_busy) begin
          state_d = ST_FINISH;
          if (status_i.op == OP_INSERT) begin
            if (status_i.hit) begin
              cmd_o.write_hit = 1'b1;
            end else if (status_i.full) begin
              // evict oldest entries before appending
              cmd_o.scan_start = 1'b1;
              cmd_o.scan_mode  = SCAN_SHIFT;
              state_d          = ST_SHIFT;
            end else begin
              cmd_o.append = 1'b1;
            end
          end
        end
      end
      ST_SHIFT: begin
        if (!status_i.scan_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_APPEND;
        end
      end
      ST_APPEND: begin
        cmd_o.append = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_SWEEP: begin
        if (!status_i.scan_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register can take the result
        if (status_i.out_free) begin
          cmd_o.result_load = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.result_load |-> status_i.out_free)
    else $error("result loaded while output register busy");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.scan_start |-> !status_i.scan_busy)
    else $error("scan started while a scan runs");

  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(status_i.scan_busy) |-> $past(cmd_o.scan_start))
    else $error("scan began without a start command");
`endif

endmodule

[rtl/plt_dp.sv]
`timescale 1ns / 1ps

module plt_dp #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned KEY_BITS    = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  plt_pkg::req_t                    in_req_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output plt_pkg::rsp_t                    out_rsp_o,
  input  logic                             cfg_we_i,
  input  logic [plt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [plt_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  plt_pkg::cmd_t                    cmd_i,
  output plt_pkg::status_t                 status_o
);

  import plt_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CAP_W = (CNT_W > CAP_CFG_W) ? CNT_W : CAP_CFG_W;
  localparam int unsigned ENT_W = KEY_BITS + ADDR_W + PORT_W + LAT_W + TIME_W;
  localparam int unsigned LAT_LO = TIME_W;

  // request and configuration
  req_t                 req_q;
  logic [CAP_CFG_W-1:0] cap_q;
  logic [TMO_W-1:0]     tmo_q;

  // table occupancy and scan engine
  logic [CNT_W-1:0] count_q;
  logic             scan_active_q;
  scan_mode_e       scan_mode_q;
  logic [CNT_W-1:0] rptr_q;
  logic [CNT_W-1:0] wptr_q;
  logic             rd_pend_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             hit_q;
  logic [IDX_W-1:0] hit_idx_q;
  logic [LAT_W-1:0] hit_lat_q;

  // output register
  logic out_valid_q;
  rsp_t rsp_q;

  // entry RAM
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [ENT_W-1:0] ram_rdata;

  logic [CAP_W-1:0]    cap_ext;
  logic [CNT_W-1:0]    eff_cap;
  logic                full;
  logic [CNT_W-1:0]    drop;
  logic                issue;
  logic [KEY_BITS-1:0] req_key;
  logic [TIME_W-1:0]   age;
  logic                keep;
  logic                match;
  logic                scan_wr;
  logic [ENT_W-1:0]    new_entry;
  logic                is_lookup;

  plt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rptr_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // capacity clamped to the range 1 .. MAX_ENTRIES
  assign cap_ext = CAP_W'(cap_q);
  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CNT_W'(1);
    end else if (cap_ext > CAP_W'(MAX_ENTRIES)) begin
      eff_cap = CNT_W'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext[CNT_W-1:0];
    end
  end

  assign full = (count_q >= eff_cap);
  assign drop = count_q - eff_cap + CNT_W'(1);

  assign req_key   = req_q.peer_key[KEY_BITS-1:0];
  assign new_entry = {req_key, req_q.peer_address, req_q.peer_port,
                      req_q.latency_bits, req_q.now_time};

  assign issue = scan_active_q && (rptr_q < count_q);
  assign age   = req_q.now_time - ram_rdata[TIME_W-1:0];
  assign keep  = (age[TIME_W-1:TMO_W] == '0) && (age[TMO_W-1:0] < tmo_q);
  assign match = rd_pend_q && (scan_mode_q == SCAN_SEARCH) &&
                 (ram_rdata[ENT_W-1 -: KEY_BITS] == req_key);
  assign scan_wr = rd_pend_q && ((scan_mode_q == SCAN_SHIFT) ||
                                 ((scan_mode_q == SCAN_SWEEP) && keep));

  // compaction writes trail the reads, so they never hit an unread entry
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wptr_q[IDX_W-1:0];
    ram_wdata = ram_rdata;
    if (scan_wr) begin
      ram_we = 1'b1;
    end else if (cmd_i.write_hit) begin
      ram_we    = 1'b1;
      ram_waddr = hit_idx_q;
      ram_wdata = new_entry;
    end else if (cmd_i.append) begin
      ram_we    = 1'b1;
      ram_waddr = count_q[IDX_W-1:0];
      ram_wdata = new_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q         <= CAP_RESET;
      tmo_q         <= TMO_RESET;
      count_q       <= '0;
      scan_active_q <= 1'b0;
      scan_mode_q   <= SCAN_SEARCH;
      rptr_q        <= '0;
      wptr_q        <= '0;
      rd_pend_q     <= 1'b0;
      hit_q         <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_CAPACITY: cap_q <= cfg_data_i[CAP_CFG_W-1:0];
          CFG_TIMEOUT:  tmo_q <= cfg_data_i[TMO_W-1:0];
          default: ;
        endcase
      end

      if (cmd_i.load) begin
        hit_q <= 1'b0;
      end

      if (cmd_i.scan_start) begin
        scan_active_q <= 1'b1;
        scan_mode_q   <= cmd_i.scan_mode;
        rptr_q        <= (cmd_i.scan_mode == SCAN_SHIFT) ? drop : '0;
        wptr_q        <= '0;
        rd_pend_q     <= 1'b0;
      end else if (scan_active_q) begin
        if (issue) begin
          rptr_q <= rptr_q + CNT_W'(1);
        end
        rd_pend_q <= issue && !match;
        if (scan_wr) begin
          wptr_q <= wptr_q + CNT_W'(1);
        end
        if (match) begin
          hit_q         <= 1'b1;
          scan_active_q <= 1'b0;
        end else if (!issue && !rd_pend_q) begin
          scan_active_q <= 1'b0;
        end
      end

      if (cmd_i.commit) begin
        count_q <= wptr_q;
      end else if (cmd_i.append) begin
        count_q <= count_q + CNT_W'(1);
      end

      if (cmd_i.result_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign is_lookup = (req_q.op == OP_LOOKUP);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_req_i;
    end
    if (scan_active_q) begin
      rd_idx_q <= rptr_q[IDX_W-1:0];
    end
    if (match) begin
      hit_idx_q <= rd_idx_q;
      hit_lat_q <= ram_rdata[LAT_LO +: LAT_W];
    end
    if (cmd_i.result_load) begin
      rsp_q.status        <= is_lookup && !hit_q;
      rsp_q.found_latency <= (is_lookup && hit_q) ? hit_lat_q : '0;
      rsp_q.entry_count   <= COUNT_W'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  assign status_o.op        = req_q.op;
  assign status_o.scan_busy = scan_active_q;
  assign status_o.hit       = hit_q;
  assign status_o.full      = full;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above table depth");

  a_write_trails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan_active_q && rd_pend_q) |-> (wptr_q <= CNT_W'(rd_idx_q)))
    else $error("compaction write ahead of read");
`endif

endmodule

[rtl/peer_latency_table_fifo_age_expiry_top.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// request   in         in_valid_i/in_ready_o  in_req_i  (plt_pkg::req_t)
// response  out        out_valid_o/out_ready_i out_rsp_o (plt_pkg::rsp_t)
// config    in         cfg_we_i               cfg_idx_i, cfg_data_i
//
// One request at a time. Lookup, sweep and insert scan the entry RAM, one
// entry per cycle on its single read port; an insert that evicts scans it twice.
// Reset clears the count and sets the config to its reset values; entry RAM
// is not cleared. A new request is taken while the last response still waits
// in its register.

module peer_latency_table_fifo_age_expiry_top #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned KEY_BITS    = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  plt_pkg::req_t                  in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output plt_pkg::rsp_t                  out_rsp_o,
  input  logic                           cfg_we_i,
  input  logic [plt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [plt_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import plt_pkg::*;

  cmd_t    cmd;
  status_t status;

  plt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  plt_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

[tb/tb_peer_latency_table_fifo_age_expiry_top.sv]
`timescale 1ns / 1ps

module tb_peer_latency_table_fifo_age_expiry_top;
  import plt_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned PHASES = 12;
  localparam int unsigned PHASE_ITEMS = 108;
  localparam int unsigned POOL_SIZE = 20;
  localparam int unsigned SETTLE_CYCLES = 60;

  // Mirror of the peer table: applies each request and queues the reply it must produce.
  class peer_table_scoreboard;
    localparam int unsigned DEPTH = 16;
    localparam int unsigned KEY_WIDTH = 64;

    logic [63:0] key_mem   [DEPTH];
    logic [31:0] addr_mem  [DEPTH];
    logic [15:0] port_mem  [DEPTH];
    logic [31:0] lat_mem   [DEPTH];
    logic [63:0] stamp_mem [DEPTH];
    int unsigned live_count;
    logic [4:0]  capacity_reg;
    logic [31:0] timeout_reg;
    plt_pkg::rsp_t table_reply_q[$];
    int unsigned mismatch_count;

    function new();
      live_count = 0;
      capacity_reg = plt_pkg::CAP_RESET;
      timeout_reg = plt_pkg::TMO_RESET;
      mismatch_count = 0;
    endfunction

    function void write_config(logic [plt_pkg::CFG_IDX_W-1:0] idx,
                               logic [plt_pkg::CFG_DATA_W-1:0] data);
      if (idx == plt_pkg::CFG_CAPACITY) begin
        capacity_reg = data[4:0];
      end else if (idx == plt_pkg::CFG_TIMEOUT) begin
        timeout_reg = data;
      end
    endfunction

    function int find_slot(logic [63:0] key);
      for (int i = 0; i < live_count; i++) begin
        if (key_mem[i] == key) return i;
      end
      return -1;
    endfunction

    function void move_slot(int unsigned dst, int unsigned src);
      key_mem[dst] = key_mem[src];
      addr_mem[dst] = addr_mem[src];
      port_mem[dst] = port_mem[src];
      lat_mem[dst] = lat_mem[src];
      stamp_mem[dst] = stamp_mem[src];
    endfunction

    function void note_request(plt_pkg::req_t req);
      logic [63:0] key;
      logic [63:0] age;
      int slot;
      int unsigned cap;
      int unsigned drop;
      int unsigned keep;
      plt_pkg::rsp_t reply;
      key = req.peer_key & ({64{1'b1}} >> (64 - KEY_WIDTH));
      reply = '0;
      slot = find_slot(key);
      case (req.op)
        plt_pkg::OP_INSERT: begin
          if (slot < 0) begin
            cap = capacity_reg;
            if (cap < 1) cap = 1;
            if (cap > DEPTH) cap = DEPTH;
            // drop the oldest entries so the new one fits within capacity
            if (live_count >= cap) begin
              drop = live_count - cap + 1;
              for (int i = 0; i + drop < live_count; i++) move_slot(i, i + drop);
              live_count -= drop;
            end
            slot = live_count;
            key_mem[slot] = key;
            live_count++;
          end
          addr_mem[slot] = req.peer_address;
          port_mem[slot] = req.peer_port;
          lat_mem[slot] = req.latency_bits;
          stamp_mem[slot] = req.now_time;
        end
        plt_pkg::OP_LOOKUP: begin
          if (slot < 0) reply.status = 1'b1;
          else reply.found_latency = lat_mem[slot];
        end
        plt_pkg::OP_SWEEP: begin
          keep = 0;
          for (int r = 0; r < live_count; r++) begin
            age = req.now_time - stamp_mem[r];
            if (age < {32'd0, timeout_reg}) begin
              if (keep != r) move_slot(keep, r);
              keep++;
            end
          end
          live_count = keep;
        end
        default: ;
      endcase
      reply.entry_count = live_count[4:0];
      table_reply_q.push_back(reply);
    endfunction

    task report_mismatch(string msg);
      if (mismatch_count < 100) $display("ERROR at %0t ns: %s", $time, msg);
      mismatch_count++;
    endtask

    task check_response(plt_pkg::rsp_t got);
      plt_pkg::rsp_t want;
      if (table_reply_q.size() == 0) begin
        report_mismatch($sformatf("response %p with no request outstanding", got));
      end else begin
        want = table_reply_q.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0b, want %0b", got.status, want.status));
        if (got.found_latency !== want.found_latency)
          report_mismatch($sformatf("found_latency %h, want %h",
                                    got.found_latency, want.found_latency));
        if (got.entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count %0d, want %0d",
                                    got.entry_count, want.entry_count));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready_o;
  req_t in_req;
  logic out_valid_o;
  logic out_ready;
  rsp_t out_rsp_o;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  peer_table_scoreboard sb;
  int sender_idle_pct;
  int recv_stall_pct;
  int hold_off_left;
  logic [63:0] clock_ms;
  logic [63:0] key_pool [POOL_SIZE];

  logic [4:0] cap_plan [PHASES] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd17,
                                    5'd2, 5'd16, 5'd8, 5'd3, 5'd15, 5'd16};
  logic [31:0] tmo_plan [PHASES] = '{32'd300, 32'd60000, 32'd200, 32'hFFFF_FFFF,
                                     32'd120, 32'd0, 32'd1, 32'd400, 32'd250,
                                     32'd90, 32'd600, 32'd150};

  peer_latency_table_fifo_age_expiry_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("tb_peer_latency_table_fifo_age_expiry_top failed");
    $finish;
  end

  function automatic req_t make_req(logic [OP_W-1:0] op, logic [63:0] key,
                                    logic [31:0] addr, logic [15:0] port,
                                    logic [31:0] lat, logic [63:0] now_ms);
    req_t req;
    req.op = op;
    req.peer_key = key;
    req.peer_address = addr;
    req.peer_port = port;
    req.latency_bits = lat;
    req.now_time = now_ms;
    return req;
  endfunction

  task automatic send_request(req_t req);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (in_ready_o !== 1'b1);
    sb.note_request(req);
  endtask

  task automatic send_random();
    int pick;
    logic [OP_W-1:0] op;
    logic [63:0] key;
    pick = $urandom_range(99);
    if (pick < 45) op = OP_INSERT;
    else if (pick < 78) op = OP_LOOKUP;
    else if (pick < 95) op = OP_SWEEP;
    else op = OP_UNUSED;
    if ($urandom_range(99) < 85) key = key_pool[$urandom_range(POOL_SIZE - 1)];
    else key = {$urandom(), $urandom()};
    // jump the clock now and then, sometimes right below the wrap point
    if ($urandom_range(99) < 2) begin
      if ($urandom_range(1) == 1) clock_ms = {$urandom(), $urandom()};
      else clock_ms = 64'hFFFF_FFFF_FFFF_FF00 + $urandom_range(255);
    end else begin
      clock_ms = clock_ms + $urandom_range(40);
    end
    send_request(make_req(op, key, $urandom(), 16'($urandom()), $urandom(), clock_ms));
  endtask

  // Hold the sender until every reply is back, then let the block settle.
  task automatic drain_table();
    in_valid <= 1'b0;
    while (sb.table_reply_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_config(idx, data);
    @(posedge clk);
  endtask

  task automatic configure(logic [4:0] cap, logic [31:0] tmo);
    logic [CFG_DATA_W-1:0] cap_word;
    drain_table();
    // upper bits of the capacity word are don't-care
    cap_word = $urandom();
    cap_word[4:0] = cap;
    write_reg(CFG_CAPACITY, cap_word);
    write_reg(CFG_TIMEOUT, tmo);
  endtask

  initial begin
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid_o === 1'b1 && out_ready === 1'b1) sb.check_response(out_rsp_o);
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    sb = new();
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_left = 0;
    clock_ms = 64'd0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_req <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_CAPACITY;
    cfg_data <= '0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom(), $urandom()};
    key_pool[0] = 64'd0;
    key_pool[1] = {64{1'b1}};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, field extremes, update in place, age boundary and wrap
    send_request(make_req(OP_LOOKUP, 64'd0, 32'd0, 16'd0, 32'd0, 64'd0));
    send_request(make_req(OP_SWEEP, 64'd0, 32'd0, 16'd0, 32'd0, 64'd0));
    send_request(make_req(OP_UNUSED, '1, '1, '1, '1, '1));
    send_request(make_req(OP_INSERT, 64'd0, 32'd0, 16'd0, 32'd0, 64'd0));
    send_request(make_req(OP_INSERT, '1, '1, '1, '1, '1));
    send_request(make_req(OP_LOOKUP, '1, 32'd0, 16'd0, 32'd0, 64'd0));
    send_request(make_req(OP_LOOKUP, 64'd0, '1, '1, '1, '1));
    send_request(make_req(OP_INSERT, 64'd0, 32'hC0A8_0001, 16'd8080, 32'h3F80_0000, 64'd5));
    send_request(make_req(OP_LOOKUP, 64'd0, 32'd0, 16'd0, 32'd0, 64'd0));
    send_request(make_req(OP_SWEEP, 64'd0, 32'd0, 16'd0, 32'd0, 64'd60004));
    send_request(make_req(OP_LOOKUP, '1, 32'd0, 16'd0, 32'd0, 64'd0));
    send_request(make_req(OP_SWEEP, 64'd0, 32'd0, 16'd0, 32'd0, 64'd60005));
    send_request(make_req(OP_UNUSED, {$urandom(), $urandom()}, $urandom(),
                          16'($urandom()), $urandom(), {$urandom(), $urandom()}));

    // capacity zero behaves as one
    configure(5'd0, 32'd60000);
    send_request(make_req(OP_INSERT, 64'h11, 32'd1, 16'd1, 32'h4000_0000, 64'd10));
    send_request(make_req(OP_INSERT, 64'h22, 32'd2, 16'd2, 32'h4040_0000, 64'd11));
    send_request(make_req(OP_LOOKUP, 64'h11, 32'd0, 16'd0, 32'd0, 64'd12));
    send_request(make_req(OP_LOOKUP, 64'h22, 32'd0, 16'd0, 32'd0, 64'd12));

    // zero timeout clears everything on sweep
    configure(5'd16, 32'd0);
    send_request(make_req(OP_INSERT, 64'h33, 32'd3, 16'd3, 32'h4080_0000, 64'd20));
    send_request(make_req(OP_SWEEP, 64'd0, 32'd0, 16'd0, 32'd0, 64'd20));

    for (int p = 0; p < PHASES; p++) begin
      configure(cap_plan[p], (p == PHASES - 1) ? $urandom() : tmo_plan[p]);
      case (p % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin sender_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // stall the receiver long enough for the input side to back up
        if (p == 5 && n == 20) hold_off_left = 400;
        if (p == 3 && n == 54) drain_table();
        send_random();
      end
    end

    in_valid <= 1'b0;
    while (sb.table_reply_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.table_reply_q.size() != 0)
      sb.report_mismatch($sformatf("%0d replies never arrived", sb.table_reply_q.size()));
    if (sb.mismatch_count == 0) begin
      $display("tb_peer_latency_table_fifo_age_expiry_top passed");
    end else begin
      $display("tb_peer_latency_table_fifo_age_expiry_top failed");
    end
    $finish;
  end

endmodule

[peer_latency_table_fifo_age_expiry_top.f]
rtl/plt_pkg.sv
rtl/plt_ram.sv
rtl/plt_ctrl.sv
rtl/plt_dp.sv
rtl/peer_latency_table_fifo_age_expiry_top.sv
tb/tb_peer_latency_table_fifo_age_expiry_top.sv
